@@ hw/rtl/uuidm_pkg.sv @@
// ----------------------------------------------------------------------------
// uuidm_pkg
// Shared constants for the advertising payload UUID16 matcher: parse phase
// codes, list structure type codes, register indexes and register resets.
// ----------------------------------------------------------------------------
package uuidm_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned UUID_W  = 16;
   localparam int unsigned PHASE_W = 2;
   localparam int unsigned CSR_AW  = 4;
   localparam int unsigned CSR_DW  = 32;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [UUID_W-1:0]  uuid_type;
   typedef logic [PHASE_W-1:0] phase_type;

   // parse phases
   localparam phase_type PH_LEN  = 2'd0;
   localparam phase_type PH_TYPE = 2'd1;
   localparam phase_type PH_DATA = 2'd2;
   localparam phase_type PH_STOP = 2'd3;

   // structure types that carry 16-bit service UUID lists
   localparam byte_type AD_UUID16_PART = 8'h02;
   localparam byte_type AD_UUID16_FULL = 8'h03;

   // register indexes
   localparam logic [1:0] REG_UUID_A = 2'd0;
   localparam logic [1:0] REG_UUID_B = 2'd1;
   localparam logic [1:0] REG_UUID_C = 2'd2;
   localparam logic [1:0] REG_UUID_D = 2'd3;

   // register reset values
   localparam uuid_type UUID_A_RST = 16'h3080;
   localparam uuid_type UUID_B_RST = 16'h3081;
   localparam uuid_type UUID_C_RST = 16'h3082;
   localparam uuid_type UUID_D_RST = 16'h3083;

endpackage

@@ hw/rtl/adv_payload_uuid16_matcher.sv @@
// ----------------------------------------------------------------------------
// adv_payload_uuid16_matcher
// Walks an advertising payload byte by byte and reports whether any of four
// configured 16-bit service UUIDs appears in a complete UUID16 list.
//
// Usage:
//   Request channel (req_valid/req_ready): one payload byte per request,
//   req_last_byte marks the final byte of the payload. Non-last bytes only
//   update the parse state and produce nothing.
//   Response channel (rsp_valid/rsp_ready): one response per payload, issued
//   for the last byte, carrying rsp_uuid_found.
//   Config port (APB style, always ready): uuid_a..uuid_d at byte addresses
//   0x0, 0x4, 0x8, 0xC. Write only while no payload is in flight.
// Timing:
//   One request per cycle sustained while rsp_ready keeps up. The parse update
//   is a single combinational pass into the state registers; the response
//   appears in the cycle after the last byte is taken, from an output register.
//   While a response waits for rsp_ready, requests are still taken as long as
//   the waiting response is being taken in the same cycle; otherwise
//   req_ready drops until the output register frees up.
// Reset:
//   Synchronous, active high. Parse state returns to expecting a length byte,
//   the UUID registers return to 0x3080..0x3083, no response is pending.
// ----------------------------------------------------------------------------
module adv_payload_uuid16_matcher (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  uuidm_pkg::byte_type        req_payload_byte,
   input  logic                       req_last_byte,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_uuid_found,
   // configuration port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [uuidm_pkg::CSR_AW-1:0] paddr,
   input  logic [uuidm_pkg::CSR_DW-1:0] pwdata,
   output logic [uuidm_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);
   import uuidm_pkg::*;

   // configuration registers
   uuid_type uuid_a_ff, uuid_b_ff, uuid_c_ff, uuid_d_ff;

   // parse state
   phase_type phase_ff, phase_in;
   byte_type  left_ff, left_in;
   logic      list_ff, list_in;
   byte_type  low_ff, low_in;
   logic      half_ff, half_in;
   logic      pend_ff, pend_in;
   logic      commit_ff, commit_in;

   // output register
   logic      rsp_valid_ff, rsp_valid_in;
   logic      found_ff, found_in;

   logic      req_acc;
   logic      csr_wr;
   logic [1:0] csr_idx;
   byte_type  left_dec;
   uuid_type  uuid_word;
   logic      uuid_hit;

   assign req_ready      = !rsp_valid_ff || rsp_ready;
   assign req_acc        = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_uuid_found = found_ff;

   // ---------------------------------------------------------------- config
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         uuid_a_ff <= UUID_A_RST;
         uuid_b_ff <= UUID_B_RST;
         uuid_c_ff <= UUID_C_RST;
         uuid_d_ff <= UUID_D_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_UUID_A: uuid_a_ff <= pwdata[UUID_W-1:0];
            REG_UUID_B: uuid_b_ff <= pwdata[UUID_W-1:0];
            REG_UUID_C: uuid_c_ff <= pwdata[UUID_W-1:0];
            REG_UUID_D: uuid_d_ff <= pwdata[UUID_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_idx)
         REG_UUID_A: prdata[UUID_W-1:0] = uuid_a_ff;
         REG_UUID_B: prdata[UUID_W-1:0] = uuid_b_ff;
         REG_UUID_C: prdata[UUID_W-1:0] = uuid_c_ff;
         REG_UUID_D: prdata[UUID_W-1:0] = uuid_d_ff;
         default: prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- parse
   assign left_dec  = left_ff - 8'd1;
   assign uuid_word = {req_payload_byte, low_ff};
   assign uuid_hit  = (uuid_word == uuid_a_ff) || (uuid_word == uuid_b_ff) ||
                      (uuid_word == uuid_c_ff) || (uuid_word == uuid_d_ff);

   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      list_in   = list_ff;
      low_in    = low_ff;
      half_in   = half_ff;
      pend_in   = pend_ff;
      commit_in = commit_ff;

      unique case (phase_ff)
         PH_LEN: begin
            if (req_payload_byte == '0) begin
               phase_in = PH_STOP;
            end else begin
               left_in  = req_payload_byte;
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            list_in = (req_payload_byte == AD_UUID16_PART) ||
                      (req_payload_byte == AD_UUID16_FULL);
            half_in = 1'b0;
            pend_in = 1'b0;
            left_in = left_dec;
            if (left_dec == '0) begin
               // structure holds only a type byte: close it with nothing pending
               phase_in = PH_LEN;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (list_ff) begin
               if (!half_ff) begin
                  low_in  = req_payload_byte;
                  half_in = 1'b1;
               end else begin
                  if (uuid_hit) begin
                     pend_in = 1'b1;
                  end
                  half_in = 1'b0;
               end
            end
            left_in = left_dec;
            if (left_dec == '0) begin
               // structure complete: commit its match
               commit_in = commit_ff | pend_in;
               pend_in   = 1'b0;
               phase_in  = PH_LEN;
            end
         end
         PH_STOP: ;
         default: ;
      endcase

      found_in = commit_in;

      if (req_last_byte) begin
         phase_in  = PH_LEN;
         left_in   = '0;
         list_in   = 1'b0;
         low_in    = '0;
         half_in   = 1'b0;
         pend_in   = 1'b0;
         commit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEN;
         left_ff   <= '0;
         list_ff   <= 1'b0;
         low_ff    <= '0;
         half_ff   <= 1'b0;
         pend_ff   <= 1'b0;
         commit_ff <= 1'b0;
      end else if (req_acc) begin
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         list_ff   <= list_in;
         low_ff    <= low_in;
         half_ff   <= half_in;
         pend_ff   <= pend_in;
         commit_ff <= commit_in;
      end
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_acc && req_last_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_last_byte) begin
         found_ff <= found_in;
      end
   end

   // ---------------------------------------------------------------- checks
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_valid && req_ready && req_last_byte))
      else $error("response raised without a last-byte request");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_last_byte) |=> (phase_ff == PH_LEN) && !commit_ff && !pend_ff)
      else $error("parse state not cleared after last byte");

   a_stop_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_STOP) && !(req_acc && req_last_byte) |=> (phase_ff == PH_STOP))
      else $error("left stopped phase before end of payload");

   a_pend_needs_list: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> list_ff)
      else $error("pending match outside a UUID16 list");

endmodule

@@ tb/sv/adv_payload_uuid16_matcher_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adv_payload_uuid16_matcher_test
// Streams advertising payloads into the UUID16 matcher and checks every
// response against an in-bench parser model. Covers hand-built edge payloads,
// then random well-formed, truncated and noisy payloads under several UUID
// settings, with random idling on both channels and one long response stall.
// ----------------------------------------------------------------------------
module adv_payload_uuid16_matcher_test;
   import uuidm_pkg::*;

   typedef struct packed {
      byte_type data;
      logic     last;
   } byte_req_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   byte_type            req_payload_byte = '0;
   logic                req_last_byte = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_uuid_found;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [CSR_AW-1:0]   paddr = '0;
   logic [CSR_DW-1:0]   pwdata = '0;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   // parser model state
   uuid_type   match_uuid [0:3] = '{UUID_A_RST, UUID_B_RST, UUID_C_RST, UUID_D_RST};
   phase_type  ps_phase = PH_LEN;
   byte_type   ps_left = '0;
   bit         ps_is_list = 1'b0;
   byte_type   ps_low = '0;
   bit         ps_high_next = 1'b0;
   bit         ps_pending = 1'b0;
   bit         ps_committed = 1'b0;

   byte_req_type req_stream [$];
   bit         found_q [$];
   bit         req_fire = 1'b0;
   bit         rsp_hold = 1'b0;
   bit         hold_go = 1'b0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         error_count = 0;

   adv_payload_uuid16_matcher uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_uuid_found   (rsp_uuid_found),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void close_structure();
      ps_committed = ps_committed | ps_pending;
      ps_pending = 1'b0;
      ps_phase = PH_LEN;
   endfunction

   // advance the parser by one byte; flag a response on the last byte
   function automatic void parse_byte(input byte_type b, input logic last,
                                      output bit emit, output bit found);
      uuid_type word;
      emit = 1'b0;
      found = 1'b0;
      case (ps_phase)
         PH_LEN: begin
            if (b == 8'h00) begin
               ps_phase = PH_STOP;
            end else begin
               ps_left = b;
               ps_phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            ps_is_list = (b == AD_UUID16_PART) || (b == AD_UUID16_FULL);
            ps_high_next = 1'b0;
            ps_pending = 1'b0;
            ps_left = ps_left - 8'd1;
            if (ps_left == 8'd0) begin
               close_structure();
            end else begin
               ps_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            if (ps_is_list) begin
               if (!ps_high_next) begin
                  ps_low = b;
                  ps_high_next = 1'b1;
               end else begin
                  word = {b, ps_low};
                  for (int i = 0; i < 4; i++) begin
                     if (word == match_uuid[i]) ps_pending = 1'b1;
                  end
                  ps_high_next = 1'b0;
               end
            end
            ps_left = ps_left - 8'd1;
            if (ps_left == 8'd0) close_structure();
         end
         default: begin
         end
      endcase
      if (last) begin
         emit = 1'b1;
         found = ps_committed;
         ps_phase = PH_LEN;
         ps_left = '0;
         ps_is_list = 1'b0;
         ps_low = '0;
         ps_high_next = 1'b0;
         ps_pending = 1'b0;
         ps_committed = 1'b0;
      end
   endfunction

   function automatic void queue_payload(input byte_type bytes [$]);
      byte_req_type item;
      for (int i = 0; i < bytes.size(); i++) begin
         item.data = bytes[i];
         item.last = (i == bytes.size() - 1);
         req_stream = {req_stream, item};
      end
   endfunction

   // build one random payload; return its length in bytes
   function automatic int queue_random_payload();
      byte_type bytes [$];
      int       kind;
      int       dlen;
      int       keep;
      uuid_type u;
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 12)) bytes = {bytes, byte_type'($urandom_range(255))};
      end else begin
         repeat ($urandom_range(1, 4)) begin
            dlen = ($urandom_range(19) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 9);
            bytes = {bytes, byte_type'(dlen + 1)};
            case ($urandom_range(3))
               0: bytes = {bytes, AD_UUID16_PART};
               1, 2: bytes = {bytes, AD_UUID16_FULL};
               default: bytes = {bytes, byte_type'($urandom_range(255))};
            endcase
            repeat (dlen / 2) begin
               if ($urandom_range(99) < 40) u = match_uuid[$urandom_range(3)];
               else u = uuid_type'($urandom_range(16'hFFFF));
               bytes = {bytes, u[7:0], u[15:8]};
            end
            if (dlen % 2 != 0) bytes = {bytes, byte_type'($urandom_range(255))};
         end
         if (kind < 25) begin
            // zero length stops parsing; trail some garbage after it
            bytes = {bytes, byte_type'(8'h00)};
            repeat ($urandom_range(0, 4)) bytes = {bytes, byte_type'($urandom_range(255))};
         end else if (kind < 40) begin
            keep = $urandom_range(1, bytes.size());
            while (bytes.size() > keep) void'(bytes.pop_back());
         end
      end
      queue_payload(bytes);
      return bytes.size();
   endfunction

   task automatic write_uuid(input logic [1:0] idx, input uuid_type value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_AW'({idx, 2'b00});
      pwdata <= CSR_DW'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      match_uuid[idx] = value;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic load_uuids(input uuid_type a, input uuid_type b,
                             input uuid_type c, input uuid_type d);
      write_uuid(REG_UUID_A, a);
      write_uuid(REG_UUID_B, b);
      write_uuid(REG_UUID_C, c);
      write_uuid(REG_UUID_D, d);
   endtask

   // wait until every request is taken and every response is back
   task automatic drain();
      while (req_stream.size() != 0 || req_valid || found_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random(input int n_bytes);
      int sent;
      sent = 0;
      while (sent < n_bytes) sent += queue_random_payload();
   endtask

   always @(negedge clock) begin : drive_requests
      byte_req_type cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur = req_stream.pop_front();
            req_valid <= 1'b1;
            req_payload_byte <= cur.data;
            req_last_byte <= cur.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_ready
      if (reset || rsp_hold) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      bit emit;
      bit found;
      bit want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            parse_byte(req_payload_byte, req_last_byte, emit, found);
            if (emit) found_q = {found_q, found};
         end
         if (rsp_valid && rsp_ready) begin
            if (found_q.size() == 0) begin
               $error("uuid_found: no response expected, actual %0b", rsp_uuid_found);
               error_count++;
            end else begin
               want = found_q.pop_front();
               if (rsp_uuid_found !== want) begin
                  $error("uuid_found: expected %0b, actual %0b", want, rsp_uuid_found);
                  error_count++;
               end
            end
         end
      end
   end

   // hold off responses long enough for the request side to back up
   initial begin : long_hold
      wait (hold_go);
      repeat (40) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #5000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin : main
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      recv_idle_pct = 85;
      // list ending exactly on the last byte
      queue_payload('{8'h03, AD_UUID16_FULL, 8'h80, 8'h30});
      // match, then zero length; trailing bytes ignored
      queue_payload('{8'h03, AD_UUID16_PART, 8'h81, 8'h30, 8'h00, 8'hFF});
      // structure cut short by the end of payload
      queue_payload('{8'h05, AD_UUID16_FULL, 8'h82, 8'h30});
      // payload ends right after a length byte
      queue_payload('{8'hFF});
      // odd trailing byte, then a non-list structure
      queue_payload('{8'h04, AD_UUID16_FULL, 8'h83, 8'h30, 8'h7F, 8'h02, 8'h16, 8'h00});
      // type-only structure
      queue_payload('{8'h01, AD_UUID16_FULL});
      drain();

      load_uuids(16'h0000, 16'hFFFF, uuid_type'($urandom_range(16'hFFFF)),
                 uuid_type'($urandom_range(16'hFFFF)));
      run_random(670);
      drain();

      send_idle_pct = 85;
      recv_idle_pct = 16;
      load_uuids(uuid_type'($urandom_range(16'hFFFF)), uuid_type'($urandom_range(16'hFFFF)),
                 uuid_type'($urandom_range(16'hFFFF)), uuid_type'($urandom_range(16'hFFFF)));
      run_random(670);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_uuids(16'hFFFF, 16'h0000, 16'hFFFF, uuid_type'($urandom_range(16'hFFFF)));
      run_random(670);
      hold_go = 1'b1;
      drain();
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
